// ===== rtl/core/scrd_pkg.sv =====
// Shared types, constants and register map of the speech chip reply deframer.
package scrd_pkg;

	localparam int BUF_DEPTH_DEF = 128;
	localparam int CNT_W         = 17;
	localparam int LEN_W         = 16;
	localparam int PADDR_W       = 5;
	localparam int PDATA_W       = 32;
	localparam int REG_IDX_W     = 3;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_HEADER    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACK_INIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACK_OK    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ACK_ERROR = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACK_BUSY  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ACK_IDLE  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_GAP = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_LONG_GAP  = 3'd7;

	localparam logic [7:0] RST_HEADER    = 8'hFC;
	localparam logic [7:0] RST_ACK_INIT  = 8'd74;
	localparam logic [7:0] RST_ACK_OK    = 8'd65;
	localparam logic [7:0] RST_ACK_ERROR = 8'd69;
	localparam logic [7:0] RST_ACK_BUSY  = 8'd78;
	localparam logic [7:0] RST_ACK_IDLE  = 8'd79;
	localparam logic [7:0] RST_SHORT_GAP = 8'd10;
	localparam logic [7:0] RST_LONG_GAP  = 8'd30;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic [6:0] read_index;
	} item_t;

	typedef struct packed {
		logic             done_res;
		logic [7:0]       last_ack;
		logic             in_frame;
		logic [LEN_W-1:0] frame_length;
		logic [CNT_W-1:0] byte_count;
		logic [7:0]       read_data;
	} result_t;

	typedef struct packed {
		logic             done_res;
		logic [7:0]       last_ack;
		logic             in_frame;
		logic [LEN_W-1:0] frame_length;
		logic [CNT_W-1:0] byte_count;
	} status_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] ack_init_code;
		logic [7:0] ack_ok_code;
		logic [7:0] ack_error_code;
		logic [7:0] ack_busy_code;
		logic [7:0] ack_idle_code;
		logic [7:0] short_gap_limit;
		logic [7:0] long_gap_limit;
	} cfg_t;

endpackage

// ===== rtl/core/speech_chip_reply_deframer.sv =====
// Top level of the speech chip reply deframer.
//
//  channel  | signals                              | beat
//  ---------+--------------------------------------+-------------------------------
//  item     | item_valid, item_stall, item         | op, rx_byte, read_index
//  result   | result_valid, result_stall, result   | one result beat per item beat
//  config   | psel, penable, pwrite, paddr, pwdata | 8-bit registers at 4*i
//
// One item per cycle sustained while the result is not stalled.
// Stage 1 holds the accepted item; the state update, buffer write and buffer read
// happen as it moves into the result register.
// Reset clears all frame state and restores register defaults; buffer is not cleared.
// A stalled result holds; the item side stalls only when both stages are full and the
// result is stalled.
module speech_chip_reply_deframer #(
	parameter int BUF_DEPTH = scrd_pkg::BUF_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  scrd_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output scrd_pkg::result_t            result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scrd_pkg::PADDR_W-1:0] paddr,
	input  logic [scrd_pkg::PDATA_W-1:0] pwdata,
	output logic [scrd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import scrd_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);

	cfg_t          cfg;
	item_t         item_s1;
	logic          v_s1;
	logic          v_s2;
	status_t       status;
	status_t       status_s2;
	logic          rd_hit_s2;
	logic          adv;
	logic          fire;
	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic          rd_hit;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign adv        = !v_s2 || !result_stall;
	assign fire       = v_s1 && adv;
	assign item_stall = v_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire) begin
			status_s2 <= status;
			rd_hit_s2 <= rd_hit;
		end
	end

	scrd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	scrd_engine #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.status (status),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_hit (rd_hit),
		.rd_addr(rd_addr)
	);

	scrd_ram #(
		.DEPTH(BUF_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign pready              = 1'b1;
	assign result_valid        = v_s2;
	assign result.done_res     = status_s2.done_res;
	assign result.last_ack     = status_s2.last_ack;
	assign result.in_frame     = status_s2.in_frame;
	assign result.frame_length = status_s2.frame_length;
	assign result.byte_count   = status_s2.byte_count;
	assign result.read_data    = rd_hit_s2 ? rd_data : 8'd0;

endmodule

// ===== rtl/core/scrd_regs.sv =====
// APB configuration registers of the reply deframer.
module scrd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scrd_pkg::PADDR_W-1:0]  paddr,
	input  logic [scrd_pkg::PDATA_W-1:0]  pwdata,
	output logic [scrd_pkg::PDATA_W-1:0]  prdata,
	output scrd_pkg::cfg_t                cfg
);
	import scrd_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	logic [7:0]           rd_val;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte     <= RST_HEADER;
			cfg_q.ack_init_code   <= RST_ACK_INIT;
			cfg_q.ack_ok_code     <= RST_ACK_OK;
			cfg_q.ack_error_code  <= RST_ACK_ERROR;
			cfg_q.ack_busy_code   <= RST_ACK_BUSY;
			cfg_q.ack_idle_code   <= RST_ACK_IDLE;
			cfg_q.short_gap_limit <= RST_SHORT_GAP;
			cfg_q.long_gap_limit  <= RST_LONG_GAP;
		end else if (wr_en) begin
			case (idx)
				REG_HEADER:    cfg_q.header_byte     <= pwdata[7:0];
				REG_ACK_INIT:  cfg_q.ack_init_code   <= pwdata[7:0];
				REG_ACK_OK:    cfg_q.ack_ok_code     <= pwdata[7:0];
				REG_ACK_ERROR: cfg_q.ack_error_code  <= pwdata[7:0];
				REG_ACK_BUSY:  cfg_q.ack_busy_code   <= pwdata[7:0];
				REG_ACK_IDLE:  cfg_q.ack_idle_code   <= pwdata[7:0];
				REG_SHORT_GAP: cfg_q.short_gap_limit <= pwdata[7:0];
				REG_LONG_GAP:  cfg_q.long_gap_limit  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HEADER:    rd_val = cfg_q.header_byte;
			REG_ACK_INIT:  rd_val = cfg_q.ack_init_code;
			REG_ACK_OK:    rd_val = cfg_q.ack_ok_code;
			REG_ACK_ERROR: rd_val = cfg_q.ack_error_code;
			REG_ACK_BUSY:  rd_val = cfg_q.ack_busy_code;
			REG_ACK_IDLE:  rd_val = cfg_q.ack_idle_code;
			REG_SHORT_GAP: rd_val = cfg_q.short_gap_limit;
			REG_LONG_GAP:  rd_val = cfg_q.long_gap_limit;
			default:       rd_val = 8'd0;
		endcase
	end

	assign prdata = PDATA_W'(rd_val);
	assign cfg    = cfg_q;

endmodule

// ===== rtl/core/scrd_ram.sv =====
// Frame byte buffer: one write port, one registered read port.
module scrd_ram #(
	parameter int DEPTH = scrd_pkg::BUF_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/scrd_engine.sv =====
// Frame state, gap timer and acknowledge latch: one update per beat.
module scrd_engine #(
	parameter int BUF_DEPTH = scrd_pkg::BUF_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  scrd_pkg::item_t              item,
	input  scrd_pkg::cfg_t               cfg,
	output scrd_pkg::status_t            status,
	output logic                         wr_en,
	output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
	output logic [7:0]                   wr_data,
	output logic                         rd_en,
	output logic                         rd_hit,
	output logic [$clog2(BUF_DEPTH)-1:0] rd_addr
);
	import scrd_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);

	localparam logic [1:0] PH_LEN_HI = 2'd0;
	localparam logic [1:0] PH_LEN_LO = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	logic             active_q, active_d;
	logic [1:0]       phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             short_q, short_d;
	logic             long_q, long_d;
	logic [7:0]       gap_q, gap_d;
	logic             done_q, done_d;
	logic [7:0]       ack_q, ack_d;

	logic             store;
	logic [CNT_W-1:0] store_pos;
	logic [CNT_W-1:0] len_lim;
	logic [CNT_W-1:0] idx_ext;
	logic [7:0]       b;
	logic [7:0]       limit;
	logic             ack_hit;

	assign b       = item.rx_byte;
	assign len_lim = CNT_W'(len_q) + CNT_W'(3);
	assign ack_hit = (b == cfg.ack_init_code) || (b == cfg.ack_ok_code) ||
		(b == cfg.ack_error_code) || (b == cfg.ack_busy_code) ||
		(b == cfg.ack_idle_code);
	assign limit   = long_q ? cfg.long_gap_limit : cfg.short_gap_limit;

	always_comb begin
		active_d  = active_q;
		phase_d   = phase_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		short_d   = short_q;
		long_d    = long_q;
		gap_d     = gap_q;
		done_d    = done_q;
		ack_d     = ack_q;
		store     = 1'b0;
		store_pos = cnt_q;
		case (item.op)
			OP_BYTE: begin
				if (!active_q) begin
					if (b == cfg.header_byte) begin
						gap_d     = 8'd0;
						store     = 1'b1;
						store_pos = '0;
						cnt_d     = CNT_W'(1);
						short_d   = 1'b1;
						active_d  = 1'b1;
						done_d    = 1'b0;
						phase_d   = PH_LEN_HI;
						len_d     = '0;
					end else if (ack_hit) begin
						ack_d  = b;
						done_d = 1'b1;
					end
				end else begin
					case (phase_q)
						PH_LEN_HI: begin
							len_d   = {b, 8'd0};
							store   = 1'b1;
							cnt_d   = cnt_q + CNT_W'(1);
							phase_d = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							len_d   = (len_q[15:8] == 8'd0 && b == 8'd1) ?
								'0 : {len_q[15:8], b};
							store   = 1'b1;
							cnt_d   = cnt_q + CNT_W'(1);
							phase_d = PH_DATA;
						end
						PH_DATA: begin
							if (cnt_q <= len_lim) begin
								store = 1'b1;
								cnt_d = cnt_q + CNT_W'(1);
							end
							if (len_q > LEN_W'(2)) begin
								long_d = 1'b1;
							end else begin
								short_d = 1'b0;
							end
						end
						default: ;
					endcase
					// frame complete
					if (phase_d == PH_DATA && cnt_d == CNT_W'(len_d) + CNT_W'(4)) begin
						done_d   = 1'b1;
						short_d  = 1'b0;
						long_d   = 1'b0;
						gap_d    = 8'd0;
						phase_d  = PH_LEN_HI;
						len_d    = '0;
						active_d = 1'b0;
					end
				end
			end
			OP_TICK: begin
				if (short_q || long_q) begin
					gap_d = gap_q + 8'd1;
					if (gap_d > limit) begin
						short_d  = 1'b0;
						long_d   = 1'b0;
						gap_d    = 8'd0;
						done_d   = 1'b1;
						active_d = 1'b0;
					end
				end
			end
			OP_CLEAR: done_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= PH_LEN_HI;
			len_q    <= '0;
			cnt_q    <= '0;
			short_q  <= 1'b0;
			long_q   <= 1'b0;
			gap_q    <= 8'd0;
			done_q   <= 1'b0;
			ack_q    <= 8'd0;
		end else if (fire) begin
			active_q <= active_d;
			phase_q  <= phase_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			short_q  <= short_d;
			long_q   <= long_d;
			gap_q    <= gap_d;
			done_q   <= done_d;
			ack_q    <= ack_d;
		end
	end

	assign wr_en   = fire && store && (store_pos < CNT_W'(BUF_DEPTH));
	assign wr_addr = store_pos[AW-1:0];
	assign wr_data = b;

	assign idx_ext = CNT_W'(item.read_index);
	assign rd_hit  = (item.op == OP_READ) && (idx_ext < CNT_W'(BUF_DEPTH));
	assign rd_en   = fire && rd_hit;
	assign rd_addr = idx_ext[AW-1:0];

	assign status.done_res     = done_d;
	assign status.last_ack     = ack_d;
	assign status.in_frame     = active_d;
	assign status.frame_length = len_d;
	assign status.byte_count   = cnt_d;

endmodule
